// ===== design/aesb_pkg.sv =====
// ----------------------------------------------------------------------------
// aesb_pkg
// Shared codes, constants and the default substitution table.
// ----------------------------------------------------------------------------
package aesb_pkg;

  typedef logic [1:0] func_t;

  localparam func_t FUNC_LOAD_KEY  = 2'd0;
  localparam func_t FUNC_LOAD_SBOX = 2'd1;
  localparam func_t FUNC_LOW_HALF  = 2'd2;
  localparam func_t FUNC_HIGH_HALF = 2'd3;

  localparam int          KEY_WORDS   = 22;
  localparam int          KEY_AW      = 5;
  localparam logic [7:0]  REDUCE_POLY = 8'h1B;
  localparam logic [7:0]  TOP_BIT     = 8'h80;
  localparam logic [3:0]  LAST_ROUND  = 4'd10;

  localparam logic [7:0] STD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (((x & TOP_BIT) != 8'h00) ? REDUCE_POLY : 8'h00);
  endfunction

endpackage

// ===== design/aesb_ram.sv =====
// ----------------------------------------------------------------------------
// aesb_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module aesb_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/aes128_block_encrypt.sv =====
// Output: once the rounds for the high-half item are done, one result per
// cycle without stall (two results per block).
// No new input is taken until both results are out; the single S-box read
// port handles one byte per cycle in each of ten rounds of substitution.
// Reset: S-box returns to the standard table, pending low half clears, the
// round key store is undefined until loaded.
// ----------------------------------------------------------------------------
// aes128_block_encrypt
// Byte-serial AES-128 encryption over a loaded, expanded key schedule.
// ----------------------------------------------------------------------------
module aes128_block_encrypt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  aesb_pkg::func_t      func_i,
  input  logic [7:0]           index_i,
  input  logic [63:0]          data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [63:0]          out_half_o,
  output logic                 last_o
);
  import aesb_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_KEY  = 3'd1;
  localparam logic [2:0] ST_SUB  = 3'd2;
  localparam logic [2:0] ST_COL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]   state_q, state_d;
  logic [4:0]   cnt_q, cnt_d;
  logic [3:0]   rnd_q, rnd_d;
  logic         last_q, last_d;
  logic [63:0]  pend_q;
  logic [127:0] s_q, t_q;
  logic [63:0]  kw0_q, kw1_q;
  logic [255:0] sb_valid_q;
  logic         vld_q;
  logic [7:0]   std_q;

  logic         in_acc, out_acc;
  logic         key_we, sb_we;
  logic [KEY_AW-1:0] key_raddr;
  logic [63:0]  key_rdata;
  logic [7:0]   sb_raddr, sb_rdata, sub_byte;
  logic [3:0]   src_idx, dst_idx;
  logic [127:0] col_src;
  logic [31:0]  col, col_mix, col_key, col_new;
  logic [63:0]  kw_sel;
  logic [7:0]   a0, a1, a2, a3, tx;
  logic         do_mix;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign last_o      = last_q;
  assign out_half_o  = last_q ? s_q[127:64] : s_q[63:0];

  assign key_we = in_acc && (func_i == FUNC_LOAD_KEY) && (index_i < 8'(KEY_WORDS));
  assign sb_we  = in_acc && (func_i == FUNC_LOAD_SBOX);
  assign key_raddr = {rnd_q, cnt_q[0]};

  assign src_idx  = {cnt_q[3:2] + cnt_q[1:0], cnt_q[1:0]};
  assign sb_raddr = s_q[8*src_idx +: 8];
  assign sub_byte = vld_q ? sb_rdata : std_q;
  assign dst_idx  = 4'(cnt_q - 5'd1);

  aesb_ram #(.Width(64), .Depth(KEY_WORDS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (index_i[KEY_AW-1:0]),
    .wdata_i (data_i),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  aesb_ram #(.Width(8), .Depth(256)) u_sbox_ram (
    .clk_i   (clk_i),
    .we_i    (sb_we),
    .waddr_i (index_i),
    .wdata_i (data_i[7:0]),
    .raddr_i (sb_raddr),
    .rdata_o (sb_rdata)
  );

  assign do_mix  = (rnd_q != 4'd0) && (rnd_q != LAST_ROUND);
  assign col_src = (rnd_q == 4'd0) ? s_q : t_q;
  assign col     = col_src[32*cnt_q[1:0] +: 32];
  assign a0 = col[7:0];
  assign a1 = col[15:8];
  assign a2 = col[23:16];
  assign a3 = col[31:24];
  assign tx = a0 ^ a1 ^ a2 ^ a3;
  assign col_mix = {a3 ^ tx ^ xtime(a3 ^ a0), a2 ^ tx ^ xtime(a2 ^ a3),
                    a1 ^ tx ^ xtime(a1 ^ a2), a0 ^ tx ^ xtime(a0 ^ a1)};
  assign kw_sel  = cnt_q[1] ? kw1_q : kw0_q;
  assign col_key = cnt_q[0] ? kw_sel[63:32] : kw_sel[31:0];
  assign col_new = (do_mix ? col_mix : col) ^ col_key;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rnd_d   = rnd_q;
    last_d  = last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && func_i == FUNC_HIGH_HALF) begin
          state_d = ST_KEY;
          cnt_d   = 5'd0;
          rnd_d   = 4'd0;
        end
      end
      ST_KEY: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd2) begin
          state_d = ST_COL;
          cnt_d   = 5'd0;
        end
      end
      ST_SUB: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd16) begin
          state_d = ST_KEY;
          cnt_d   = 5'd0;
        end
      end
      ST_COL: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd3) begin
          cnt_d = 5'd0;
          if (rnd_q == LAST_ROUND) begin
            state_d = ST_OUT;
            last_d  = 1'b0;
          end else begin
            state_d = ST_SUB;
            rnd_d   = rnd_q + 4'd1;
          end
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          if (last_q) begin
            state_d = ST_IDLE;
            last_d  = 1'b0;
          end else begin
            last_d = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      rnd_q      <= '0;
      last_q     <= 1'b0;
      pend_q     <= '0;
      sb_valid_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      last_q  <= last_d;
      if (in_acc && func_i == FUNC_LOW_HALF) begin
        pend_q <= data_i;
      end
      if (sb_we) begin
        sb_valid_q[index_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && func_i == FUNC_HIGH_HALF) begin
      s_q <= {data_i, pend_q};
    end
    if (state_q == ST_SUB) begin
      vld_q <= sb_valid_q[sb_raddr];
      std_q <= STD_SBOX[sb_raddr];
      if (cnt_q != 5'd0) begin
        t_q[8*dst_idx +: 8] <= sub_byte;
      end
    end
    if (state_q == ST_KEY) begin
      if (cnt_q == 5'd1) begin
        kw0_q <= key_rdata;
      end
      if (cnt_q == 5'd2) begin
        kw1_q <= key_rdata;
      end
    end
    if (state_q == ST_COL) begin
      s_q[32*cnt_q[1:0] +: 32] <= col_new;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && last_o)
    else $error("high half does not follow low half");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !out_valid_o)
    else $error("extra result after high half");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i == FUNC_HIGH_HALF |=> !out_valid_o)
    else $error("result without encryption rounds");

endmodule
